### sv/pid_controller_clamped_assert.svh
// assertion macros shared by the checker of the clamped pid controller
`ifndef PID_CONTROLLER_CLAMPED_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_ASSERT_SVH

// consequent holds in the cycle after the antecedent
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcc check failed");

// consequent holds in the same cycle as the antecedent
`define PCC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcc check failed");

`endif

### sv/pcc_pkg.sv
// shared types, widths and constants of the clamped pid controller
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;

	// operand widths of the serial multiplier and divider
	localparam int MUL_AW  = 64;
	localparam int MUL_BW  = 33;
	localparam int PROD_W  = MUL_AW + MUL_BW;
	localparam int DIV_NW  = 65;
	localparam int DIV_DW  = 16;

	// 256000 / 2^16 reduces to 125 / 2^5, used by both time scalings
	localparam logic [DIV_DW-1:0] TIME_SCALE = 16'd125;

	// request codes
	typedef enum logic [1:0] {
		REQ_DIFF = 2'd0,
		REQ_RATE = 2'd1,
		REQ_CLR  = 2'd2,
		REQ_NOP  = 2'd3
	} req_t;

	// register indexes
	localparam logic [2:0] CFG_GAIN_P   = 3'd0;
	localparam logic [2:0] CFG_GAIN_I   = 3'd1;
	localparam logic [2:0] CFG_GAIN_D   = 3'd2;
	localparam logic [2:0] CFG_OUT_LOW  = 3'd3;
	localparam logic [2:0] CFG_OUT_HIGH = 3'd4;

endpackage
`default_nettype wire

### sv/pcc_mul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pcc_mul (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pcc_pkg::MUL_AW-1:0]  a,
	input  wire logic [pcc_pkg::MUL_BW-1:0]  b,
	output logic                             done,
	output logic [pcc_pkg::PROD_W-1:0]       product
);
	logic [pcc_pkg::PROD_W-1:0] acc_q;
	logic [pcc_pkg::MUL_AW-1:0] a_q;
	logic [pcc_pkg::MUL_BW-1:0] b_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pcc_pkg::MUL_AW:0]   part;

	// add the multiplicand into the upper half when the current bit is set
	assign part = {1'b0, acc_q[pcc_pkg::PROD_W-1:pcc_pkg::MUL_BW]}
		+ (b_q[0] ? {1'b0, a_q} : '0);

	// payload shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= {part, acc_q[pcc_pkg::MUL_BW-1:1]};
			b_q   <= b_q >> 1;
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 6'(pcc_pkg::MUL_BW - 1));
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(pcc_pkg::MUL_BW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule
`default_nettype wire

### sv/pcc_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pcc_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [pcc_pkg::DIV_NW-1:0]  dividend,
	input  wire logic [pcc_pkg::DIV_DW-1:0]  divisor,
	output logic                             done,
	output logic [pcc_pkg::DIV_NW-1:0]       quotient
);
	logic [pcc_pkg::DIV_NW-1:0] quo_q;
	logic [pcc_pkg::DIV_DW-1:0] rem_q;
	logic [pcc_pkg::DIV_DW-1:0] dvs_q;
	logic [6:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pcc_pkg::DIV_DW+1:0] trial;

	// trial subtract of the divisor from the partial remainder
	assign trial = {1'b0, rem_q, quo_q[pcc_pkg::DIV_NW-1]} - {2'b00, dvs_q};

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pcc_pkg::DIV_NW-2:0], ~trial[pcc_pkg::DIV_DW+1]};
			if (!trial[pcc_pkg::DIV_DW+1])
				rem_q <= trial[pcc_pkg::DIV_DW-1:0];
			else
				rem_q <= {rem_q[pcc_pkg::DIV_DW-2:0], quo_q[pcc_pkg::DIV_NW-1]};
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 7'(pcc_pkg::DIV_NW - 1));
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(pcc_pkg::DIV_NW - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

### sv/pid_controller_clamped.sv
// Clamped PID controller, top level.
// Input channel (in_valid / in_stall) carries a request: req_type, error,
// error_rate and dt_step. Compute requests (difference or supplied rate)
// give one drive value on the output channel (out_valid / out_stall);
// an integral clear request and the unused code give no result.
// Gains and clamp limits are written through cfg_we / cfg_index / cfg_data;
// the user must write them only while the block is idle, which the block
// itself does not enforce. The state resets to idle; the datapath registers
// have no reset. Each compute request runs through one shared bit-serial
// multiplier (five 64-by-33-bit products) and one bit-serial divider (two
// 65-bit quotients); with dt_step of zero the derivative path is skipped,
// leaving three products and one quotient. A new request is taken at the
// earliest while out_valid is high, so the block works on one compute
// request at a time. A clear request clears the integral and leaves the
// block idle.
// in_stall is high while a request is in work. The result sits in an
// output register; a new request is taken while it waits, and a finished
// request waits in its last step while the receiver stalls.
// arst_n clears gains, limits, the integral and the last error.
`timescale 1ns / 1ps
`default_nettype none
module pid_controller_clamped (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic signed [31:0] error,
	input  wire logic signed [31:0] error_rate,
	input  wire logic [15:0]        dt_step,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      drive
);
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_MUL_P  = 10'b0000000010,
		ST_MUL_I1 = 10'b0000000100,
		ST_MUL_I2 = 10'b0000001000,
		ST_DIV_I  = 10'b0000010000,
		ST_MUL_D1 = 10'b0000100000,
		ST_MUL_D2 = 10'b0001000000,
		ST_DIV_D  = 10'b0010000000,
		ST_SUM    = 10'b0100000000,
		ST_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0] gain_p_q, gain_i_q, gain_d_q, out_low_q, out_high_q;
	logic [31:0] last_error_q;
	logic [47:0] integral_q;
	logic        err_neg_q, x_neg_q;
	logic [31:0] err_mag_q;
	logic [32:0] x_mag_q;
	logic [15:0] dt_q;
	logic [63:0] p_q, d_q, sum_q;
	logic [31:0] drive_q;
	logic        out_valid_q;

	logic                        mul_go_q, mul_done;
	logic [pcc_pkg::MUL_AW-1:0]  mul_a_q;
	logic [pcc_pkg::MUL_BW-1:0]  mul_b_q;
	logic [pcc_pkg::PROD_W-1:0]  product;
	logic                        div_go_q, div_done;
	logic [pcc_pkg::DIV_NW-1:0]  div_n_q;
	logic [pcc_pkg::DIV_DW-1:0]  div_d_q;
	logic [pcc_pkg::DIV_NW-1:0]  quotient;

	logic        accept;
	logic        out_free;
	logic        mul_launch, div_launch;
	logic [32:0] x_in;
	logic [32:0] x_abs;
	logic [31:0] err_abs;
	logic [31:0] gp_abs, gi_abs, gd_abs;
	logic [62:0] p_mag;
	logic [49:0] di_s, int_sum;
	logic [47:0] int_next;
	logic [62:0] d_mag;
	logic [64:0] s65;
	logic [63:0] u_sat, u_clamp, lim_hi, lim_lo;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// error change or supplied rate and magnitudes of the operands
	assign x_in    = (req_type == pcc_pkg::REQ_DIFF)
		? ({error[31], error} - {last_error_q[31], last_error_q})
		: {error_rate[31], error_rate};
	assign x_abs   = x_in[32] ? (33'd0 - x_in) : x_in;
	assign err_abs = error[31] ? (32'd0 - error) : error;
	assign gp_abs  = gain_p_q[31] ? (32'd0 - gain_p_q) : gain_p_q;
	assign gi_abs  = gain_i_q[31] ? (32'd0 - gain_i_q) : gain_i_q;
	assign gd_abs  = gain_d_q[31] ? (32'd0 - gain_d_q) : gain_d_q;

	// proportional term, product scaled down by the fraction bits
	assign p_mag = product[78:16];

	// integral increment and saturating update
	assign di_s     = (gain_i_q[31] ^ err_neg_q) ? (50'd0 - {5'd0, quotient[44:0]})
		: {5'd0, quotient[44:0]};
	assign int_sum  = {{2{integral_q[47]}}, integral_q} + di_s;
	assign int_next = (int_sum[49:47] == 3'b000 || int_sum[49:47] == 3'b111)
		? int_sum[47:0]
		: (int_sum[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});

	// derivative magnitude capped at the signed 64-bit range
	assign d_mag = (quotient[64:63] != 2'b00) ? {63{1'b1}} : quotient[62:0];

	// final saturating add and clamp
	assign s65     = {sum_q[63], sum_q} + {d_q[63], d_q};
	assign u_sat   = (s65[64] != s65[63])
		? (s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : s65[63:0];
	assign lim_hi  = {{32{out_high_q[31]}}, out_high_q};
	assign lim_lo  = {{32{out_low_q[31]}}, out_low_q};
	assign u_clamp = ($signed(u_sat) > $signed(lim_hi)) ? lim_hi
		: (($signed(u_sat) < $signed(lim_lo)) ? lim_lo : u_sat);

	// launch conditions of the multiplier and divider
	assign mul_launch = (accept && (req_type == pcc_pkg::REQ_DIFF
			|| req_type == pcc_pkg::REQ_RATE))
		|| (mul_done && (state_q == ST_MUL_P || state_q == ST_MUL_I1
			|| state_q == ST_MUL_D1))
		|| (div_done && state_q == ST_DIV_I && dt_q != 16'd0);
	assign div_launch = mul_done && (state_q == ST_MUL_I2 || state_q == ST_MUL_D2);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			out_low_q  <= '0;
			out_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcc_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data;
				pcc_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data;
				pcc_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data;
				pcc_pkg::CFG_OUT_LOW:  out_low_q  <= cfg_data;
				pcc_pkg::CFG_OUT_HIGH: out_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request operands and intermediate terms
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					err_neg_q <= error[31];
					err_mag_q <= err_abs;
					x_neg_q   <= x_in[32];
					x_mag_q   <= x_abs;
					dt_q      <= dt_step;
					mul_a_q   <= {32'd0, gp_abs};
					mul_b_q   <= {1'b0, err_abs};
				end
			end
			ST_MUL_P: begin
				if (mul_done) begin
					p_q     <= (gain_p_q[31] ^ err_neg_q) ? (64'd0 - {1'b0, p_mag})
						: {1'b0, p_mag};
					mul_a_q <= {32'd0, gi_abs};
					mul_b_q <= {1'b0, err_mag_q};
				end
			end
			ST_MUL_I1: begin
				if (mul_done) begin
					mul_a_q <= product[63:0];
					mul_b_q <= {17'd0, dt_q};
				end
			end
			ST_MUL_I2: begin
				if (mul_done) begin
					div_n_q <= product[91:27];
					div_d_q <= pcc_pkg::TIME_SCALE;
				end
			end
			ST_DIV_I: begin
				if (div_done) begin
					d_q     <= '0;
					mul_a_q <= {32'd0, gd_abs};
					mul_b_q <= x_mag_q;
				end
			end
			ST_MUL_D1: begin
				if (mul_done) begin
					mul_a_q <= product[63:0];
					mul_b_q <= {17'd0, pcc_pkg::TIME_SCALE};
				end
			end
			ST_MUL_D2: begin
				if (mul_done) begin
					div_n_q <= product[69:5];
					div_d_q <= dt_q;
				end
			end
			ST_DIV_D: begin
				if (div_done)
					d_q <= (gain_d_q[31] ^ x_neg_q) ? (64'd0 - {1'b0, d_mag})
						: {1'b0, d_mag};
			end
			ST_SUM: begin
				sum_q <= p_q + {{16{integral_q[47]}}, integral_q};
			end
			ST_OUT: begin
				if (out_free)
					drive_q <= u_clamp[31:0];
			end
			default: ;
		endcase
	end

	// launch pulses of the shared units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			mul_go_q <= mul_launch;
			div_go_q <= div_launch;
		end
	end

	// result valid, set by a finished request and cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_OUT && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// sequencer over the shared multiplier and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			integral_q   <= '0;
			last_error_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == pcc_pkg::REQ_CLR) begin
							integral_q <= '0;
						end else if (req_type == pcc_pkg::REQ_DIFF
							|| req_type == pcc_pkg::REQ_RATE) begin
							last_error_q <= error;
							state_q      <= ST_MUL_P;
						end
					end
				end
				ST_MUL_P: begin
					if (mul_done)
						state_q <= ST_MUL_I1;
				end
				ST_MUL_I1: begin
					if (mul_done)
						state_q <= ST_MUL_I2;
				end
				ST_MUL_I2: begin
					if (mul_done)
						state_q <= ST_DIV_I;
				end
				ST_DIV_I: begin
					if (div_done) begin
						integral_q <= int_next;
						if (dt_q == 16'd0)
							state_q <= ST_SUM;
						else
							state_q <= ST_MUL_D1;
					end
				end
				ST_MUL_D1: begin
					if (mul_done)
						state_q <= ST_MUL_D2;
				end
				ST_MUL_D2: begin
					if (mul_done)
						state_q <= ST_DIV_D;
				end
				ST_DIV_D: begin
					if (div_done)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// shared arithmetic units
	pcc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.a       (mul_a_q),
		.b       (mul_b_q),
		.done    (mul_done),
		.product (product)
	);

	pcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_n_q),
		.divisor  (div_d_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
endmodule
`default_nettype wire

### sv/pcc_checker.sv
// port-level checker of the clamped pid controller and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "pid_controller_clamped_assert.svh"
module pcc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [1:0]  req_type,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] drive
);
	// a compute request occupies the block in the next cycle
	`PCC_ASSERT_NEXT(a_busy_after_compute, in_valid && !in_stall && (req_type == pcc_pkg::REQ_DIFF || req_type == pcc_pkg::REQ_RATE), in_stall)
	// a clear request leaves the block free
	`PCC_ASSERT_NEXT(a_free_after_clear, in_valid && !in_stall && req_type == pcc_pkg::REQ_CLR, !in_stall)
	// no result appears right after a request is taken from idle
	`PCC_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall && !out_valid, !out_valid)
	// a stalled result holds
	`PCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(drive))
	// a new result never shows while the block is free and nothing was pending
	`PCC_ASSERT_NOW(a_result_needs_work, $rose(out_valid), $past(in_stall))
endmodule

bind pid_controller_clamped pcc_checker u_pcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.drive     (drive)
);
`default_nettype wire
